[hdl/pbrc_pkg.sv]
`timescale 1ns / 1ps
package pbrc_pkg;
   localparam int CoordWidth = 24;
   localparam int DirWidth   = 16;
   localparam int CountWidth = 5;
   localparam int IndexWidth = 4;
   localparam int DefMaxPanels     = 16;
   localparam int DefMaxBadRegions = 16;

   localparam logic [1:0] REQ_QUERY     = 2'd0;
   localparam logic [1:0] REQ_PANEL_WR  = 2'd1;
   localparam logic [1:0] REQ_BAD_WR    = 2'd2;

   localparam logic CSR_PANEL_COUNT = 1'b0;
   localparam logic CSR_BAD_COUNT   = 1'b1;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DirWidth-1:0]   dir_type;
endpackage

[hdl/pixel_bad_region_check_core.sv]
`timescale 1ns / 1ps
// A transaction's response is registered through the match, subtract/multiply,
// sum/round/saturate and bad-region compare stages, the last of which is the
// output register.
// Throughput: one transaction per cycle; a stalled response stalls all stages
// together, so nothing is dropped or repeated.
// Reset: synchronous, active high; clears both counts and all stage valid bits.
// The panel and bad-region tables are not cleared and must be written before use.
module pixel_bad_region_check_core #(
   parameter int MAX_PANELS      = pbrc_pkg::DefMaxPanels,
   parameter int MAX_BAD_REGIONS = pbrc_pkg::DefMaxBadRegions
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_type,
   input  logic [3:0]                   req_entry_index,
   input  pbrc_pkg::coord_type          req_first_low,
   input  pbrc_pkg::coord_type          req_first_high,
   input  pbrc_pkg::coord_type          req_second_low,
   input  pbrc_pkg::coord_type          req_second_high,
   input  pbrc_pkg::dir_type            req_fs_to_x,
   input  pbrc_pkg::dir_type            req_fs_to_y,
   input  pbrc_pkg::dir_type            req_ss_to_x,
   input  pbrc_pkg::dir_type            req_ss_to_y,
   input  pbrc_pkg::coord_type          req_corner_x,
   input  pbrc_pkg::coord_type          req_corner_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_is_bad,
   output logic                         rsp_panel_found,
   output logic [3:0]                   rsp_panel_index,
   output pbrc_pkg::coord_type          rsp_lab_x,
   output pbrc_pkg::coord_type          rsp_lab_y,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [4:0]                   csr_write_data
);
   import pbrc_pkg::*;

   localparam int PIdxW = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
   localparam int PCntW = $clog2(MAX_PANELS + 1);
   localparam int BCntW = $clog2(MAX_BAD_REGIONS + 1);

   // Tables live in flip-flops: every entry is compared in parallel each cycle.
   coord_type p_fs_lo [MAX_PANELS];
   coord_type p_fs_hi [MAX_PANELS];
   coord_type p_ss_lo [MAX_PANELS];
   coord_type p_ss_hi [MAX_PANELS];
   dir_type   p_fx [MAX_PANELS];
   dir_type   p_fy [MAX_PANELS];
   dir_type   p_sx [MAX_PANELS];
   dir_type   p_sy [MAX_PANELS];
   coord_type p_cx [MAX_PANELS];
   coord_type p_cy [MAX_PANELS];
   coord_type b_x_lo [MAX_BAD_REGIONS];
   coord_type b_x_hi [MAX_BAD_REGIONS];
   coord_type b_y_lo [MAX_BAD_REGIONS];
   coord_type b_y_hi [MAX_BAD_REGIONS];

   logic [PCntW-1:0] panel_count_ff;
   logic [BCntW-1:0] bad_count_ff;

   // One enable moves the whole pipeline; the last stage is the output register.
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   assign advance   = !s4_valid_ff || rsp_ready;
   assign req_ready = advance;

   logic accept;
   assign accept = req_valid && req_ready;

   // Counts saturate at the table depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         panel_count_ff <= '0;
         bad_count_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PANEL_COUNT: panel_count_ff <= (32'(csr_write_data) > MAX_PANELS) ?
                                PCntW'(MAX_PANELS) : PCntW'(csr_write_data);
            CSR_BAD_COUNT:   bad_count_ff <= (32'(csr_write_data) > MAX_BAD_REGIONS) ?
                                BCntW'(MAX_BAD_REGIONS) : BCntW'(csr_write_data);
            default: ;
         endcase
      end
   end

   // Table writes; an index beyond the depth is dropped.
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_PANEL_WR && 32'(req_entry_index) < MAX_PANELS) begin
         p_fs_lo[PIdxW'(req_entry_index)] <= req_first_low;
         p_fs_hi[PIdxW'(req_entry_index)] <= req_first_high;
         p_ss_lo[PIdxW'(req_entry_index)] <= req_second_low;
         p_ss_hi[PIdxW'(req_entry_index)] <= req_second_high;
         p_fx[PIdxW'(req_entry_index)]    <= req_fs_to_x;
         p_fy[PIdxW'(req_entry_index)]    <= req_fs_to_y;
         p_sx[PIdxW'(req_entry_index)]    <= req_ss_to_x;
         p_sy[PIdxW'(req_entry_index)]    <= req_ss_to_y;
         p_cx[PIdxW'(req_entry_index)]    <= req_corner_x;
         p_cy[PIdxW'(req_entry_index)]    <= req_corner_y;
      end
   end

   localparam int BIdxW = (MAX_BAD_REGIONS > 1) ? $clog2(MAX_BAD_REGIONS) : 1;

   // The bad-region table is read by queries in the last stage, so a bad-region
   // write travels down the pipeline and lands as it leaves the third stage.
   // Queries ahead of it have already been judged, and queries behind it see it.
   logic             s1_bwr_ff, s2_bwr_ff, s3_bwr_ff;
   logic [BIdxW-1:0] s1_bidx_ff, s2_bidx_ff, s3_bidx_ff;
   coord_type        s1_bxhi_ff, s1_byhi_ff;
   coord_type        s2_bxlo_ff, s2_bxhi_ff, s2_bylo_ff, s2_byhi_ff;
   coord_type        s3_bxlo_ff, s3_bxhi_ff, s3_bylo_ff, s3_byhi_ff;

   always_ff @(posedge clock) begin
      if (!reset && advance && s3_valid_ff && s3_bwr_ff) begin
         b_x_lo[s3_bidx_ff] <= s3_bxlo_ff;
         b_x_hi[s3_bidx_ff] <= s3_bxhi_ff;
         b_y_lo[s3_bidx_ff] <= s3_bylo_ff;
         b_y_hi[s3_bidx_ff] <= s3_byhi_ff;
      end
   end

   // Stage 1: compare the query against every panel and pick the first hit.
   logic [MAX_PANELS-1:0] hit;
   always_comb begin
      for (int i = 0; i < MAX_PANELS; i++) begin
         hit[i] = (i < 32'(panel_count_ff)) &&
                  req_first_low >= p_fs_lo[i] && req_first_low <= p_fs_hi[i] &&
                  req_second_low >= p_ss_lo[i] && req_second_low <= p_ss_hi[i];
      end
   end

   logic             found_in;
   logic [PIdxW-1:0] pidx_in;
   always_comb begin
      found_in = 1'b0;
      pidx_in  = '0;
      for (int i = MAX_PANELS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found_in = 1'b1;
            pidx_in  = PIdxW'(i);
         end
      end
   end

   logic             s1_query_ff, s1_found_ff;
   logic [PIdxW-1:0] s1_pidx_ff;
   coord_type        s1_fs_ff, s1_ss_ff;

   // Stage 2: relative position (25-bit) and the four products.
   logic signed [CoordWidth:0] rf_in, rs_in;
   assign rf_in = 25'(s1_fs_ff) - 25'(p_fs_lo[s1_pidx_ff]);
   assign rs_in = 25'(s1_ss_ff) - 25'(p_ss_lo[s1_pidx_ff]);

   logic s2_query_ff, s2_found_ff;
   logic [PIdxW-1:0] s2_pidx_ff;
   logic signed [40:0] s2_pfx_ff, s2_pfy_ff, s2_psx_ff, s2_psy_ff;
   coord_type s2_cx_ff, s2_cy_ff;

   // Stage 3: sum, round half up, saturate.
   function automatic coord_type map_sum(input logic signed [40:0] a,
                                         input logic signed [40:0] b,
                                         input coord_type c);
      logic signed [43:0] acc;
      logic signed [29:0] r;
      begin
         acc = 44'(a) + 44'(b) + (44'(c) <<< 14) + 44'sd8192;
         r   = 30'(acc >>> 14);
         if (r > 30'sd8388607)       map_sum = 24'sh7fffff;
         else if (r < -30'sd8388608) map_sum = 24'sh800000;
         else                        map_sum = r[CoordWidth-1:0];
      end
   endfunction

   logic s3_query_ff, s3_found_ff;
   logic [PIdxW-1:0] s3_pidx_ff;
   coord_type s3_x_ff, s3_y_ff;

   // Stage 4: test the lab position against every bad region.
   logic in_bad;
   always_comb begin
      in_bad = 1'b0;
      for (int i = 0; i < MAX_BAD_REGIONS; i++) begin
         if ((i < 32'(bad_count_ff)) &&
             s3_x_ff >= b_x_lo[i] && s3_x_ff <= b_x_hi[i] &&
             s3_y_ff >= b_y_lo[i] && s3_y_ff <= b_y_hi[i])
            in_bad = 1'b1;
      end
   end

   logic s4_bad_ff, s4_found_ff;
   logic [PIdxW-1:0] s4_pidx_ff;
   coord_type s4_x_ff, s4_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_query_ff <= req_type == REQ_QUERY;
         s1_found_ff <= found_in;
         s1_pidx_ff  <= pidx_in;
         s1_fs_ff    <= req_first_low;
         s1_ss_ff    <= req_second_low;
         s1_bwr_ff   <= req_type == REQ_BAD_WR &&
                        32'(req_entry_index) < MAX_BAD_REGIONS;
         s1_bidx_ff  <= BIdxW'(req_entry_index);
         s1_bxhi_ff  <= req_first_high;
         s1_byhi_ff  <= req_second_high;

         s2_query_ff <= s1_query_ff;
         s2_found_ff <= s1_found_ff;
         s2_pidx_ff  <= s1_pidx_ff;
         s2_pfx_ff   <= 41'(rf_in) * 41'(p_fx[s1_pidx_ff]);
         s2_pfy_ff   <= 41'(rf_in) * 41'(p_fy[s1_pidx_ff]);
         s2_psx_ff   <= 41'(rs_in) * 41'(p_sx[s1_pidx_ff]);
         s2_psy_ff   <= 41'(rs_in) * 41'(p_sy[s1_pidx_ff]);
         s2_cx_ff    <= p_cx[s1_pidx_ff];
         s2_cy_ff    <= p_cy[s1_pidx_ff];
         s2_bwr_ff   <= s1_bwr_ff;
         s2_bidx_ff  <= s1_bidx_ff;
         s2_bxlo_ff  <= s1_fs_ff;
         s2_bxhi_ff  <= s1_bxhi_ff;
         s2_bylo_ff  <= s1_ss_ff;
         s2_byhi_ff  <= s1_byhi_ff;

         s3_query_ff <= s2_query_ff;
         s3_found_ff <= s2_query_ff && s2_found_ff;
         s3_pidx_ff  <= s2_pidx_ff;
         s3_x_ff     <= map_sum(s2_pfx_ff, s2_psx_ff, s2_cx_ff);
         s3_y_ff     <= map_sum(s2_pfy_ff, s2_psy_ff, s2_cy_ff);
         s3_bwr_ff   <= s2_bwr_ff;
         s3_bidx_ff  <= s2_bidx_ff;
         s3_bxlo_ff  <= s2_bxlo_ff;
         s3_bxhi_ff  <= s2_bxhi_ff;
         s3_bylo_ff  <= s2_bylo_ff;
         s3_byhi_ff  <= s2_byhi_ff;

         s4_found_ff <= s3_found_ff;
         s4_bad_ff   <= s3_query_ff && (!s3_found_ff || in_bad);
         s4_pidx_ff  <= s3_found_ff ? s3_pidx_ff : '0;
         s4_x_ff     <= s3_found_ff ? s3_x_ff : '0;
         s4_y_ff     <= s3_found_ff ? s3_y_ff : '0;
      end
   end

   assign rsp_valid       = s4_valid_ff;
   assign rsp_is_bad      = s4_bad_ff;
   assign rsp_panel_found = s4_found_ff;
   assign rsp_panel_index = 4'(s4_pidx_ff);
   assign rsp_lab_x       = s4_x_ff;
   assign rsp_lab_y       = s4_y_ff;
endmodule

[hdl/pbrc_checker.sv]
`timescale 1ns / 1ps
module pbrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_bad,
   input logic        rsp_panel_found,
   input logic [3:0]  rsp_panel_index,
   input logic [23:0] rsp_lab_x
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lab_x) &&
         $stable(rsp_is_bad) && $stable(rsp_panel_found) && $stable(rsp_panel_index))
      else $error("response changed while stalled");
   a_notfound_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_panel_found |-> rsp_panel_index == 4'd0 && rsp_lab_x == 24'd0)
      else $error("empty fields expected without a panel");
   a_ready_follow: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input stalled without output backpressure");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind pixel_bad_region_check_core pbrc_checker u_pbrc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_is_bad(rsp_is_bad),
   .rsp_panel_found(rsp_panel_found), .rsp_panel_index(rsp_panel_index),
   .rsp_lab_x(rsp_lab_x)
);
